[rtl/vae_pkg.sv]
// Package for the VT100 attribute escape encoder.
// Holds the opcode codes, attribute bit positions, terminal byte codes and
// the command word that the front end passes to the byte serializer.
package vae_pkg;

  typedef enum logic [1:0] {
    OP_CELL   = 2'd0,
    OP_NORMAL = 2'd1,
    OP_END    = 2'd2,
    OP_NONE   = 2'd3
  } vae_op_e;

  localparam int unsigned AttrW = 5;

  localparam int unsigned AttrG1    = 0;
  localparam int unsigned AttrUnder = 1;
  localparam int unsigned AttrBlink = 2;
  localparam int unsigned AttrRever = 3;
  localparam int unsigned AttrBold  = 4;

  localparam logic [AttrW-1:0] AttrVideo = 5'b11110;

  localparam logic [7:0] ByteSo   = 8'h0E;
  localparam logic [7:0] ByteSi   = 8'h0F;
  localparam logic [7:0] ByteEsc  = 8'h1B;
  localparam logic [7:0] ByteLbr  = 8'h5B;
  localparam logic [7:0] ByteM    = 8'h6D;
  localparam logic [7:0] SelBold  = 8'h31;
  localparam logic [7:0] SelUnder = 8'h34;
  localparam logic [7:0] SelBlink = 8'h35;
  localparam logic [7:0] SelRever = 8'h37;

  // Segments of one command, sent in index order.
  localparam int unsigned SegNum   = 7;
  localparam int unsigned SegG1    = 0;
  localparam int unsigned SegClr   = 1;
  localparam int unsigned SegBold  = 2;
  localparam int unsigned SegUnder = 3;
  localparam int unsigned SegBlink = 4;
  localparam int unsigned SegRever = 5;
  localparam int unsigned SegChr   = 6;

  typedef struct packed {
    logic              g1_so;
    logic [SegNum-1:0] segs;
    logic [7:0]        chr;
  } vae_cmd_t;

endpackage

[rtl/vae_if.sv]
// Handshake interfaces for the encoder's request and byte channels.
// Depends on nothing; widths follow the cell and byte fields.
interface vae_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [4:0] attr_flags;

  modport source (output valid, output opcode, output char_code, output attr_flags,
                  input ready);
  modport sink (input valid, input opcode, input char_code, input attr_flags,
                output ready);
endinterface

interface vae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

[rtl/vae_front.sv]
// Front end: accepts requests, tracks the terminal attributes and turns each
// request needing bytes into a command word of segments. Depends on vae_pkg.
module vae_front
  import vae_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [7:0]       char_code_i,
  input  logic [AttrW-1:0] attr_flags_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output vae_cmd_t         push_cmd_o
);

  logic [AttrW-1:0] attrs_q, attrs_d;
  logic [AttrW-1:0] cur_clr;
  logic [AttrW-1:0] need;
  logic             accept;
  vae_cmd_t         cmd;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    cmd        = '0;
    cmd.chr    = char_code_i;
    attrs_d    = attrs_q;
    cur_clr    = attrs_q;
    need       = '0;
    unique case (vae_op_e'(opcode_i))
      OP_CELL: begin
        cmd.segs[SegG1] = attr_flags_i[AttrG1] ^ attrs_q[AttrG1];
        cmd.g1_so       = attr_flags_i[AttrG1];
        cmd.segs[SegClr] = |(~attr_flags_i & attrs_q & AttrVideo);
        if (cmd.segs[SegClr]) begin
          cur_clr = attrs_q & ~AttrVideo;
        end
        need = attr_flags_i & ~cur_clr;
        cmd.segs[SegBold]  = need[AttrBold];
        cmd.segs[SegUnder] = need[AttrUnder];
        cmd.segs[SegBlink] = need[AttrBlink];
        cmd.segs[SegRever] = need[AttrRever];
        cmd.segs[SegChr]   = 1'b1;
        attrs_d = attr_flags_i;
      end
      OP_NORMAL: begin
        cmd.segs[SegClr] = |(attrs_q & AttrVideo);
        attrs_d = attrs_q & ~AttrVideo;
      end
      OP_END: begin
        cmd.segs[SegG1]  = attrs_q[AttrG1];
        cmd.g1_so        = 1'b0;
        cmd.segs[SegClr] = |(attrs_q & AttrVideo);
        attrs_d = '0;
      end
      default: begin
        attrs_d = attrs_q;
      end
    endcase
  end

  assign push_cmd_o   = cmd;
  assign push_valid_o = in_valid_i && (|cmd.segs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attrs_q <= '0;
    end else if (accept) begin
      attrs_q <= attrs_d;
    end
  end

endmodule

[rtl/vae_queue.sv]
// Short command queue between the front end and the byte serializer.
// Depends on vae_pkg for the command word.
module vae_queue
  import vae_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  vae_cmd_t push_cmd_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output vae_cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  vae_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/vae_back.sv]
// Byte serializer: walks each command's segments and sends one byte a cycle
// through an output register unless the receiver stalls. Depends on vae_pkg.
module vae_back
  import vae_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  vae_cmd_t pop_cmd_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic [7:0] out_byte_o,
  output logic     out_last_o
);

  logic [SegNum-1:0] pend_q, pend_d, low, rest;
  logic              g1_so_q, g1_so_d;
  logic [7:0]        chr_q, chr_d;
  logic [1:0]        pos_q, pos_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        obyte_q, obyte_d;
  logic              olast_q, olast_d;
  logic              busy, advance, seg_done, final_byte, pop;
  logic [7:0]        sel, byte_now;

  assign busy    = |pend_q;
  assign advance = !ovalid_q || out_ready_i;
  assign low     = pend_q & (~pend_q + 1'b1);
  assign rest    = pend_q & ~low;

  always_comb begin
    sel      = SelBold;
    byte_now = chr_q;
    seg_done = 1'b1;
    if (low[SegG1]) begin
      byte_now = g1_so_q ? ByteSo : ByteSi;
    end else if (low[SegChr]) begin
      byte_now = chr_q;
    end else begin
      if (low[SegUnder]) begin
        sel = SelUnder;
      end else if (low[SegBlink]) begin
        sel = SelBlink;
      end else if (low[SegRever]) begin
        sel = SelRever;
      end
      case (pos_q)
        2'd0: byte_now = ByteEsc;
        2'd1: byte_now = ByteLbr;
        2'd2: byte_now = low[SegClr] ? ByteM : sel;
        default: byte_now = ByteM;
      endcase
      seg_done = low[SegClr] ? (pos_q == 2'd2) : (pos_q == 2'd3);
    end
  end

  assign final_byte  = seg_done && (rest == '0);
  assign pop         = pop_valid_i && (!busy || (advance && final_byte));
  assign pop_ready_o = !busy || (advance && final_byte);

  always_comb begin
    pend_d   = pend_q;
    g1_so_d  = g1_so_q;
    chr_d    = chr_q;
    pos_d    = pos_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (advance) begin
      ovalid_d = busy;
      if (busy) begin
        obyte_d = byte_now;
        olast_d = final_byte;
        if (seg_done) begin
          pend_d = rest;
          pos_d  = 2'd0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
    if (pop) begin
      pend_d  = pop_cmd_i.segs;
      g1_so_d = pop_cmd_i.g1_so;
      chr_d   = pop_cmd_i.chr;
      pos_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g1_so_q <= g1_so_d;
    chr_q   <= chr_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

[rtl/vt100_attribute_escape_encoder_unit.sv]
// Channel  Role    Payload                          Handshake
// in_i     sink    opcode, char_code, attr_flags    valid/ready
// out_o    source  out_byte, last_byte              valid/ready
//
// Requests are taken one per cycle while the command queue has room.
// Bytes leave one per cycle from the output register while out_o is ready;
// a request holds the serializer per byte it makes; a plain cell makes one.
// Reset clears the terminal attributes to plain video with G0 selected.
// Either side may stall; the queue of QueueDepth commands absorbs the slack.
module vt100_attribute_escape_encoder_unit
  import vae_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vae_in_if.sink    in_i,
  vae_out_if.source out_o
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  vae_cmd_t push_cmd, pop_cmd;

  vae_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .opcode_i     (in_i.opcode),
    .char_code_i  (in_i.char_code),
    .attr_flags_i (in_i.attr_flags),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  vae_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  vae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last_byte)
  );

endmodule

[rtl/vae_checker.sv]
// Port-level checks on the encoder's byte channel, bound to the top level.
// Depends on vae_pkg for the terminal byte codes.
module vae_checker
  import vae_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  logic taken;
  logic esc_seen_q, lbr_seen_q;

  assign taken = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_seen_q <= 1'b0;
      lbr_seen_q <= 1'b0;
    end else if (taken) begin
      esc_seen_q <= (out_byte_i == ByteEsc) && !out_last_i;
      lbr_seen_q <= esc_seen_q;
    end
  end

  // The output register is empty while reset is applied.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("byte valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_last_i))
    else $error("stalled byte changed");

  // An escape that does not end a request opens a control sequence.
  a_after_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_seen_q && out_valid_i |-> out_byte_i == ByteLbr && !out_last_i)
    else $error("escape not followed by bracket");

  a_after_lbr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbr_seen_q && out_valid_i |-> out_byte_i == ByteM || out_byte_i == SelBold
      || out_byte_i == SelUnder || out_byte_i == SelBlink || out_byte_i == SelRever)
    else $error("bad selector after bracket");

endmodule

bind vt100_attribute_escape_encoder_unit vae_checker u_vae_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last_byte)
);

[dv/tb_vt100_attribute_escape_encoder_unit.sv]
// Testbench for the VT100 attribute escape encoder unit.
// It drives every opcode and checks each terminal byte against a predictor.
// It depends on vae_pkg and the vae_in_if and vae_out_if interfaces.
module tb_vt100_attribute_escape_encoder_unit;
  import vae_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } term_byte_t;

  typedef struct packed {
    vae_op_e          op;
    logic [7:0]       chr;
    logic [AttrW-1:0] attr;
    int               n_typed;
    logic [31:0]      typed;
  } cell_row_t;

  localparam logic [7:0] SelNone = 8'h00;
  localparam int NumRows = 26;
  localparam int NumRandom = 144;
  localparam int HoldCycles = 300;
  localparam int MaxShown = 10;
  localparam int TailCycles = 40;

  // A typed count of -1 means the row is checked against the predictor.
  localparam cell_row_t CellTable [NumRows] = '{
    '{OP_CELL,   8'h41, 5'h00,  1, 32'h41},
    '{OP_NORMAL, 8'h00, 5'h00,  0, 32'h0},
    '{OP_END,    8'h00, 5'h00,  0, 32'h0},
    '{OP_NONE,   8'hFF, 5'h1F,  0, 32'h0},
    '{OP_CELL,   8'h00, 5'h01,  2, 32'h0E00},
    '{OP_CELL,   8'h7F, 5'h01,  1, 32'h7F},
    '{OP_CELL,   8'h20, 5'h00,  2, 32'h0F20},
    '{OP_CELL,   8'hFF, 5'h1F, -1, 32'h0},
    '{OP_CELL,   8'h41, 5'h1E, -1, 32'h0},
    '{OP_CELL,   8'h42, 5'h01, -1, 32'h0},
    '{OP_CELL,   8'h43, 5'h1F, -1, 32'h0},
    '{OP_CELL,   8'h44, 5'h10, -1, 32'h0},
    '{OP_NORMAL, 8'h00, 5'h00,  3, 32'h1B5B6D},
    '{OP_NORMAL, 8'hFF, 5'h1F,  0, 32'h0},
    '{OP_CELL,   8'h45, 5'h03, -1, 32'h0},
    '{OP_END,    8'h00, 5'h00,  4, 32'h0F1B5B6D},
    '{OP_END,    8'hFF, 5'h1F,  0, 32'h0},
    '{OP_CELL,   8'h00, 5'h10, -1, 32'h0},
    '{OP_CELL,   8'h80, 5'h0F, -1, 32'h0},
    '{OP_NONE,   8'h5A, 5'h15,  0, 32'h0},
    '{OP_CELL,   8'hFF, 5'h0F,  1, 32'hFF},
    '{OP_END,    8'h00, 5'h00, -1, 32'h0},
    '{OP_CELL,   8'h01, 5'h01, -1, 32'h0},
    '{OP_NORMAL, 8'h00, 5'h00,  0, 32'h0},
    '{OP_END,    8'h00, 5'h00,  1, 32'h0F},
    '{OP_NONE,   8'h00, 5'h00,  0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             req_valid = 1'b0;
  vae_op_e          req_op = OP_NONE;
  logic [7:0]       req_chr = 8'h00;
  logic [AttrW-1:0] req_attr = '0;
  logic             rx_ready = 1'b0;

  int tx_idle_pct = 18;
  int rx_idle_pct = 52;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int n_err = 0;

  logic [AttrW-1:0] term_attrs = '0;
  logic [7:0]       burst[$];
  term_byte_t       tx_q[$];

  vae_in_if  in_if ();
  vae_out_if out_if ();

  assign in_if.valid = req_valid;
  assign in_if.opcode = req_op;
  assign in_if.char_code = req_chr;
  assign in_if.attr_flags = req_attr;
  assign out_if.ready = rx_ready;

  vt100_attribute_escape_encoder_unit u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_sgr(input logic [7:0] sel);
    burst.push_back(ByteEsc);
    burst.push_back(ByteLbr);
    if (sel != SelNone) burst.push_back(sel);
    burst.push_back(ByteM);
  endfunction

  function automatic void encode_request(input vae_op_e op, input logic [7:0] chr,
                                         input logic [AttrW-1:0] want);
    logic [AttrW-1:0] cur;
    cur = term_attrs;
    burst.delete();
    case (op)
      OP_CELL: begin
        if (want != cur) begin
          if (want[AttrG1] != cur[AttrG1]) begin
            burst.push_back(want[AttrG1] ? ByteSo : ByteSi);
            cur[AttrG1] = want[AttrG1];
          end
          if ((~want & cur & AttrVideo) != '0) begin
            add_sgr(SelNone);
            cur = cur & ~AttrVideo;
          end
          if (want[AttrBold] != cur[AttrBold]) begin
            add_sgr(SelBold);
            cur[AttrBold] = 1'b1;
          end
          if (want[AttrUnder] != cur[AttrUnder]) begin
            add_sgr(SelUnder);
            cur[AttrUnder] = 1'b1;
          end
          if (want[AttrBlink] != cur[AttrBlink]) begin
            add_sgr(SelBlink);
            cur[AttrBlink] = 1'b1;
          end
          if (want[AttrRever] != cur[AttrRever]) begin
            add_sgr(SelRever);
            cur[AttrRever] = 1'b1;
          end
        end
        burst.push_back(chr);
      end
      OP_NORMAL: begin
        if ((cur & AttrVideo) != '0) begin
          add_sgr(SelNone);
          cur = cur & ~AttrVideo;
        end
      end
      OP_END: begin
        if (cur[AttrG1]) burst.push_back(ByteSi);
        if ((cur & AttrVideo) != '0) add_sgr(SelNone);
        cur = '0;
      end
      default: begin
      end
    endcase
    term_attrs = cur;
  endfunction

  function automatic void note_error(input string msg);
    if (n_err < MaxShown) $display("%s", msg);
    n_err++;
  endfunction

  task automatic send_request(input vae_op_e op, input logic [7:0] chr,
                              input logic [AttrW-1:0] attr, input int n_typed,
                              input logic [31:0] typed);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_op <= op;
    req_chr <= chr;
    req_attr <= attr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    encode_request(op, chr, attr);
    if (n_typed >= 0) begin
      burst.delete();
      for (int k = 0; k < n_typed; k++) burst.push_back(typed[8*(n_typed-1-k) +: 8]);
    end
    for (int k = 0; k < burst.size(); k++) begin
      tx_q.push_back(term_byte_t'{burst[k], k == burst.size() - 1});
    end
  endtask

  always @(posedge clk) begin
    term_byte_t want_b;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tx_q.size() == 0) begin
        note_error($sformatf("unexpected byte %02h last %b", out_if.out_byte,
                             out_if.last_byte));
      end else begin
        want_b = tx_q.pop_front();
        if (out_if.out_byte !== want_b.data || out_if.last_byte !== want_b.last) begin
          note_error($sformatf("byte mismatch: expected %02h last %b, got %02h last %b",
                               want_b.data, want_b.last, out_if.out_byte,
                               out_if.last_byte));
        end
      end
    end
    if (hold_left != 0) begin
      rx_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_reqs) begin
      rx_ready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= hold_done + 1;
    end else begin
      rx_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    vae_op_e          op;
    logic [AttrW-1:0] run_attr;
    logic [AttrW-1:0] attr;
    int               pick;
    run_attr = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < NumRows; r++) begin
      send_request(CellTable[r].op, CellTable[r].chr, CellTable[r].attr,
                   CellTable[r].n_typed, CellTable[r].typed);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 48) begin
        tx_idle_pct = 52;
        rx_idle_pct = 18;
      end else if (i == 96) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (i == 20 || i == 110) hold_reqs++;
      pick = $urandom_range(99);
      if (pick < 70) op = OP_CELL;
      else if (pick < 80) op = OP_NORMAL;
      else if (pick < 92) op = OP_END;
      else op = OP_NONE;
      if ($urandom_range(99) < 60) attr = run_attr;
      else attr = AttrW'($urandom_range(31));
      if (op == OP_CELL) run_attr = attr;
      send_request(op, 8'($urandom_range(255)), attr, -1, 32'h0);
    end
    req_valid <= 1'b0;
    while (tx_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_vt100_attribute_escape_encoder_unit: done, clean");
    end else begin
      $display("tb_vt100_attribute_escape_encoder_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_vt100_attribute_escape_encoder_unit: done, errors");
    $finish;
  end

endmodule
